// File: sv/lzssd_pkg.sv
// shared types and constants of the lzss decoder
`timescale 1ns / 1ps
`default_nettype none
package lzssd_pkg;

	localparam int HISTORY_DEPTH_DEF = 4096;
	localparam int DIST_W = 12;
	localparam int LEN_W = 4;
	localparam int CMDQ_DEPTH = 4;

	localparam logic [1:0] ST_DATA   = 2'd0;
	localparam logic [1:0] ST_END    = 2'd1;
	localparam logic [1:0] ST_BADREF = 2'd2;

	localparam logic [1:0] CMD_LIT    = 2'd0;
	localparam logic [1:0] CMD_COPY   = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;
	localparam logic [1:0] CMD_BADREF = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        lit;
		logic [DIST_W-1:0] distance;
		logic [LEN_W-1:0]  lenm1;
	} cmd_t;

endpackage
`default_nettype wire

// File: sv/lzssd_in_if.sv
// compressed byte channel
`timescale 1ns / 1ps
`default_nettype none
interface lzssd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// File: sv/lzssd_out_if.sv
// decompressed result channel
`timescale 1ns / 1ps
`default_nettype none
interface lzssd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_byte, output status, output last, input ready);
	modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface
`default_nettype wire

// File: sv/lzssd_front.sv
// token parser: tracks flags and stream length, issues commands
`timescale 1ns / 1ps
`default_nettype none
module lzssd_front #(
	parameter int HISTORY_DEPTH = lzssd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	lzssd_in_if.sink            stream,
	output lzssd_pkg::cmd_t     cmd,
	output logic                cmd_valid,
	input  wire                 cmd_ready
);
	localparam int PROD_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic [PROD_W:0] PROD_MAX = (PROD_W + 1)'(HISTORY_DEPTH);

	localparam logic [1:0] PH_FLAG   = 2'd0;
	localparam logic [1:0] PH_TOKEN  = 2'd1;
	localparam logic [1:0] PH_MATCH2 = 2'd2;

	logic [1:0]        phase_q;
	logic [7:0]        flag_bits_q;
	logic [2:0]        tokens_left_q;
	logic [7:0]        dist_high_q;
	logic [PROD_W-1:0] produced_q;

	logic                        accept;
	logic [lzssd_pkg::DIST_W-1:0] distance;
	logic [lzssd_pkg::LEN_W-1:0]  lenm1;
	logic                        bad_ref;
	logic [PROD_W:0]             grow;
	logic [PROD_W:0]             sum;
	logic [PROD_W-1:0]           produced_sat;

	assign stream.ready = cmd_ready;
	assign accept = stream.valid && cmd_ready;

	assign distance = {dist_high_q, stream.in_byte[7:4]};
	assign lenm1 = stream.in_byte[3:0];
	assign bad_ref = ((PROD_W + 1)'(distance) + (PROD_W + 1)'(1)) > {1'b0, produced_q};

	always_comb begin
		grow = (PROD_W + 1)'(1);
		if (phase_q == PH_MATCH2)
			grow = (PROD_W + 1)'(lenm1) + (PROD_W + 1)'(1);
		sum = {1'b0, produced_q} + grow;
		produced_sat = (sum > PROD_MAX) ? PROD_W'(HISTORY_DEPTH) : sum[PROD_W-1:0];
	end

	always_comb begin
		cmd.kind = lzssd_pkg::CMD_LIT;
		cmd.lit = stream.in_byte;
		cmd.distance = distance;
		cmd.lenm1 = lenm1;
		cmd_valid = 1'b0;
		unique case (phase_q)
			PH_TOKEN: begin
				cmd_valid = accept && !flag_bits_q[0];
			end
			PH_MATCH2: begin
				cmd_valid = accept;
				if (lenm1 == '0)
					cmd.kind = lzssd_pkg::CMD_END;
				else if (bad_ref)
					cmd.kind = lzssd_pkg::CMD_BADREF;
				else
					cmd.kind = lzssd_pkg::CMD_COPY;
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flag_bits_q <= '0;
			tokens_left_q <= '0;
			dist_high_q <= '0;
			produced_q <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_TOKEN: begin
					if (flag_bits_q[0]) begin
						dist_high_q <= stream.in_byte;
						phase_q <= PH_MATCH2;
					end else begin
						produced_q <= produced_sat;
						if (tokens_left_q == '0) begin
							phase_q <= PH_FLAG;
						end else begin
							tokens_left_q <= tokens_left_q - 3'd1;
							flag_bits_q <= flag_bits_q >> 1;
							phase_q <= PH_TOKEN;
						end
					end
				end
				PH_MATCH2: begin
					if (lenm1 == '0) begin
						phase_q <= PH_FLAG;
						flag_bits_q <= '0;
						tokens_left_q <= '0;
						dist_high_q <= '0;
						produced_q <= '0;
					end else begin
						if (!bad_ref)
							produced_q <= produced_sat;
						if (tokens_left_q == '0) begin
							phase_q <= PH_FLAG;
						end else begin
							tokens_left_q <= tokens_left_q - 3'd1;
							flag_bits_q <= flag_bits_q >> 1;
							phase_q <= PH_TOKEN;
						end
					end
				end
				default: begin
					flag_bits_q <= stream.in_byte;
					tokens_left_q <= 3'd7;
					phase_q <= PH_TOKEN;
				end
			endcase
		end
	end

	a_prod_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, produced_q} <= PROD_MAX)
		else $error("stream length count beyond window");
	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.kind == lzssd_pkg::CMD_COPY |->
		(PROD_W + 1)'(cmd.distance) < {1'b0, produced_q})
		else $error("copy issued reaching before stream start");
endmodule
`default_nettype wire

// File: sv/lzssd_cmd_fifo.sv
// small command queue between parser and copy engine
`timescale 1ns / 1ps
`default_nettype none
module lzssd_cmd_fifo (
	input  wire              clk,
	input  wire              arst_n,
	input  lzssd_pkg::cmd_t  push_cmd,
	input  wire              push_valid,
	output logic             push_ready,
	output lzssd_pkg::cmd_t  pop_cmd,
	output logic             pop_valid,
	input  wire              pop_ready
);
	localparam int DEPTH = lzssd_pkg::CMDQ_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lzssd_pkg::cmd_t    slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd = slots_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("command queue overfilled");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 || count_q == CNT_W'(DEPTH) |->
		wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");
endmodule
`default_nettype wire

// File: sv/lzssd_back.sv
// copy engine: history window, literal and match output
`timescale 1ns / 1ps
`default_nettype none
module lzssd_back #(
	parameter int HISTORY_DEPTH = lzssd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  lzssd_pkg::cmd_t  cmd,
	input  wire              cmd_valid,
	output logic             cmd_ready,
	lzssd_out_if.source      result
);
	localparam int ADDR_W = $clog2(HISTORY_DEPTH);

	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_COPY = 1'b1;

	logic [7:0]              hist_mem [HISTORY_DEPTH];
	logic                    state_q;
	logic [ADDR_W-1:0]       wp_q;
	logic [ADDR_W-1:0]       src_q;
	logic [lzssd_pkg::LEN_W-1:0] cnt_q;
	logic [7:0]              rd_q;
	logic                    byp_hit_q;
	logic [7:0]              byp_data_q;
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic [1:0]              out_status_q;
	logic                    out_last_q;

	logic              out_free;
	logic              pop;
	logic              start_copy;
	logic              wr_en;
	logic [7:0]        wr_data;
	logic [7:0]        rd_data;
	logic [ADDR_W-1:0] rd_addr;
	logic              out_load;

	assign out_free = !out_valid_q || result.ready;
	assign pop = cmd_valid && (state_q == BK_IDLE) &&
		(cmd.kind == lzssd_pkg::CMD_COPY || out_free);
	assign cmd_ready = (state_q == BK_IDLE) &&
		(cmd.kind == lzssd_pkg::CMD_COPY || out_free);
	assign start_copy = pop && cmd.kind == lzssd_pkg::CMD_COPY;
	assign rd_data = byp_hit_q ? byp_data_q : rd_q;

	assign wr_en = (pop && cmd.kind == lzssd_pkg::CMD_LIT) ||
		(state_q == BK_COPY && out_free);
	assign wr_data = (state_q == BK_COPY) ? rd_data : cmd.lit;
	assign out_load = (pop && cmd.kind != lzssd_pkg::CMD_COPY) ||
		(state_q == BK_COPY && out_free);

	always_comb begin
		if (start_copy)
			rd_addr = wp_q - ADDR_W'(cmd.distance) - ADDR_W'(1);
		else if (state_q == BK_COPY && out_free)
			rd_addr = src_q + ADDR_W'(1);
		else
			rd_addr = src_q;
	end

	// history read is registered; a write to the address being read is forwarded
	always_ff @(posedge clk) begin
		if (wr_en)
			hist_mem[wp_q] <= wr_data;
		rd_q <= hist_mem[rd_addr];
		byp_data_q <= wr_data;
		src_q <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= 8'd0;
			out_status_q <= lzssd_pkg::ST_DATA;
			out_last_q <= 1'b1;
			if (state_q == BK_COPY) begin
				out_byte_q <= rd_data;
				out_last_q <= cnt_q == '0;
			end else begin
				case (cmd.kind)
					lzssd_pkg::CMD_LIT: out_byte_q <= cmd.lit;
					lzssd_pkg::CMD_END: out_status_q <= lzssd_pkg::ST_END;
					default: out_status_q <= lzssd_pkg::ST_BADREF;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			wp_q <= '0;
			cnt_q <= '0;
			byp_hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			byp_hit_q <= wr_en && (wp_q == rd_addr);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (wr_en)
				wp_q <= wp_q + ADDR_W'(1);
			else if (pop && cmd.kind == lzssd_pkg::CMD_END)
				wp_q <= '0;
			unique case (state_q)
				BK_COPY: begin
					if (out_free) begin
						if (cnt_q == '0)
							state_q <= BK_IDLE;
						else
							cnt_q <= cnt_q - lzssd_pkg::LEN_W'(1);
					end
				end
				default: begin
					if (start_copy) begin
						state_q <= BK_COPY;
						cnt_q <= cmd.lenm1;
					end
				end
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.status = out_status_q;
	assign result.last = out_last_q;

	a_no_pop_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_COPY |-> !pop)
		else $error("command taken during a copy");
	a_write_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> out_free && out_load)
		else $error("history written without a result");
	a_flag_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != lzssd_pkg::ST_DATA |-> out_byte_q == 8'd0 && out_last_q)
		else $error("status result carries data");
	a_copy_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_COPY && out_free && cnt_q == '0 |=> state_q == BK_IDLE && out_last_q)
		else $error("copy did not end with last");
endmodule
`default_nettype wire

// File: sv/lzssd_decoder_4k_window.sv
// top level of the lzss decoder with 4096-byte history
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                       note
// stream    in   in_byte[7:0]                  flag, literal or match byte
// result    out  out_byte[7:0] status[1:0] last one request per output byte
//
// a byte is taken each cycle while the 4-entry command queue has room
// a literal, end or bad reference gives its registered result in the cycle after it leaves the queue
// a match first addresses the history ram, then writes and outputs one byte per cycle
// while the result is free, through its single write port, 2 to 16 bytes, so the queue fills
// reset clears control state at once; history is never cleared, no wait after reset
// a stalled result holds the copy engine, which then backs up the queue and input
module lzss_decoder_4k_window #(
	parameter int HISTORY_DEPTH = lzssd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	lzssd_in_if.sink     stream,
	lzssd_out_if.source  result
);
	lzssd_pkg::cmd_t push_cmd;
	logic            push_valid;
	logic            push_ready;
	lzssd_pkg::cmd_t pop_cmd;
	logic            pop_valid;
	logic            pop_ready;

	lzssd_front #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream),
		.cmd(push_cmd),
		.cmd_valid(push_valid),
		.cmd_ready(push_ready)
	);

	lzssd_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_cmd(push_cmd),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_cmd(pop_cmd),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready)
	);

	lzssd_back #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(pop_cmd),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.result(result)
	);
endmodule
`default_nettype wire

// File: sim/testbench.sv
// self-checking bench for the lzss decoder: directed and random compressed streams against a byte-exact predictor
`timescale 1ns / 1ps
module testbench;

	localparam int WINDOW = lzssd_pkg::HISTORY_DEPTH_DEF;

	typedef enum logic [1:0] {
		WANT_FLAG  = 2'd0,
		WANT_TOKEN = 2'd1,
		WANT_LEN   = 2'd2
	} dec_phase_t;

	typedef enum logic [2:0] {
		TK_NONE,
		TK_LITERAL,
		TK_COPY,
		TK_END,
		TK_BADREF
	} tok_kind_t;

	// token parsing state, shared by the predictor and the stream shaper
	typedef struct {
		dec_phase_t  phase;
		logic [7:0]  flags;
		logic [2:0]  left;
		logic [7:0]  dist_hi;
		logic [12:0] produced;
	} ctl_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} result_t;

	typedef struct {
		logic [7:0] data;
		int         gap_after;
		bit         drain_first;
	} pending_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic [7:0] src_byte = 8'd0;
	logic       sink_ready = 1'b0;

	lzssd_in_if  stream_if ();
	lzssd_out_if result_if ();

	assign stream_if.valid   = src_valid;
	assign stream_if.in_byte = src_byte;
	assign result_if.ready   = sink_ready;

	lzss_decoder_4k_window u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	pending_byte_t compressed_q[$];
	result_t       decoded_q[$];

	// predictor state
	logic [7:0]  window_mem [WINDOW];
	logic [11:0] wr_ptr = 12'd0;
	ctl_t        dec_ctl;

	// stream shaper state
	ctl_t gen_ctl;
	bit   send_calm;
	bit   drain_next;
	bit   stream_over;

	int            errors = 0;
	int            results_seen = 0;
	int            send_idle = 0;
	int            recv_idle = 0;
	int            next_hold = 60;
	logic          long_hold = 1'b0;
	logic [31:0]   cycle_cnt = 32'd0;
	pending_byte_t next_item;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic ctl_t ctl_reset();
		ctl_t s;
		s.phase    = WANT_FLAG;
		s.flags    = 8'd0;
		s.left     = 3'd0;
		s.dist_hi  = 8'd0;
		s.produced = 13'd0;
		return s;
	endfunction

	function automatic logic [12:0] sat_add(input logic [12:0] p, input int n);
		int t;
		t = int'(p) + n;
		return (t > WINDOW) ? 13'(WINDOW) : 13'(t);
	endfunction

	function automatic void next_token(inout ctl_t s);
		if (s.left == 3'd0) begin
			s.phase = WANT_FLAG;
		end else begin
			s.left  = s.left - 3'd1;
			s.flags = s.flags >> 1;
			s.phase = WANT_TOKEN;
		end
	endfunction

	function automatic tok_kind_t parse_byte(inout ctl_t s, input logic [7:0] b,
			output logic [11:0] distance, output logic [3:0] lenm1);
		tok_kind_t kind;
		kind     = TK_NONE;
		distance = {s.dist_hi, b[7:4]};
		lenm1    = b[3:0];
		case (s.phase)
			WANT_TOKEN: begin
				if (!s.flags[0]) begin
					kind       = TK_LITERAL;
					s.produced = sat_add(s.produced, 1);
					next_token(s);
				end else begin
					s.dist_hi = b;
					s.phase   = WANT_LEN;
				end
			end
			WANT_LEN: begin
				if (lenm1 == 4'd0) begin
					kind = TK_END;
					s    = ctl_reset();
				end else if (int'(distance) + 1 > int'(s.produced)) begin
					// reaches before the first byte of this stream, dropped
					kind = TK_BADREF;
					next_token(s);
				end else begin
					kind       = TK_COPY;
					s.produced = sat_add(s.produced, int'(lenm1) + 1);
					next_token(s);
				end
			end
			default: begin
				s.flags = b;
				s.left  = 3'd7;
				s.phase = WANT_TOKEN;
			end
		endcase
		return kind;
	endfunction

	task automatic keep_byte(input logic [7:0] v);
		window_mem[wr_ptr] = v;
		wr_ptr = wr_ptr + 12'd1;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [11:0] distance;
		logic [11:0] src;
		logic [3:0]  lenm1;
		logic [7:0]  v;
		case (parse_byte(dec_ctl, b, distance, lenm1))
			TK_LITERAL: begin
				keep_byte(b);
				decoded_q.push_back(result_t'{b, lzssd_pkg::ST_DATA, 1'b1});
			end
			TK_COPY: begin
				// byte by byte so that overlapping copies repeat data
				src = wr_ptr - distance - 12'd1;
				for (int i = 0; i <= int'(lenm1); i++) begin
					v   = window_mem[src];
					src = src + 12'd1;
					keep_byte(v);
					decoded_q.push_back(result_t'{v, lzssd_pkg::ST_DATA, i == int'(lenm1)});
				end
			end
			TK_END: begin
				decoded_q.push_back(result_t'{8'd0, lzssd_pkg::ST_END, 1'b1});
				wr_ptr = 12'd0;
			end
			TK_BADREF: begin
				decoded_q.push_back(result_t'{8'd0, lzssd_pkg::ST_BADREF, 1'b1});
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] make_flag(input int lit_pct);
		logic [7:0] f;
		for (int i = 0; i < 8; i++)
			f[i] = ($urandom_range(0, 99) >= lit_pct);
		return f;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		pending_byte_t it;
		logic [11:0]   d;
		logic [3:0]    l;
		it.data        = b;
		it.gap_after   = send_calm ? 0 : pick_gap();
		it.drain_first = drain_next;
		drain_next     = 1'b0;
		compressed_q.push_back(it);
		if (parse_byte(gen_ctl, b, d, l) == TK_END)
			stream_over = 1'b1;
	endtask

	// one literal or match, with a flag byte or an open match's length byte first where one is due
	task automatic gen_token(input int lit_pct, input int bad_pct, input bit long_copy);
		logic [11:0] d;
		logic [3:0]  lm;
		int          reach;
		while (gen_ctl.phase != WANT_TOKEN) begin
			if (gen_ctl.phase == WANT_LEN)
				push_byte({4'($urandom), 4'($urandom_range(1, 15))});
			else
				push_byte(make_flag(lit_pct));
		end
		if (!gen_ctl.flags[0]) begin
			push_byte(8'($urandom));
		end else begin
			lm    = long_copy ? 4'hf : 4'($urandom_range(1, 15));
			reach = int'(gen_ctl.produced);
			if (reach == 0 || (reach < WINDOW && $urandom_range(0, 99) < bad_pct))
				d = 12'($urandom_range(reach, WINDOW - 1));
			else if ($urandom_range(0, 1) == 1)
				d = 12'($urandom_range(0, (reach < 16 ? reach : 16) - 1));
			else
				d = 12'($urandom_range(0, reach - 1));
			push_byte(d[11:4]);
			push_byte({d[3:0], lm});
		end
	endtask

	// drive the decoder to an end of stream from whatever state it is in
	task automatic close_stream();
		logic [7:0] f;
		stream_over = 1'b0;
		while (!stream_over) begin
			case (gen_ctl.phase)
				WANT_TOKEN: push_byte(8'($urandom));
				WANT_LEN: push_byte({4'($urandom), 4'h0});
				default: begin
					f    = 8'($urandom);
					f[0] = 1'b1;
					push_byte(f);
				end
			endcase
		end
	endtask

	task automatic build_stimulus();
		logic [7:0] directed [$];
		int         n0;
		int         s0;
		int         r;
		int         lp;
		bit         wrap_done;
		gen_ctl    = ctl_reset();
		send_calm  = 1'b0;
		drain_next = 1'b0;
		wrap_done  = 1'b0;
		// literals 00 and ff, overlapping 16-byte copy, short copy, bad reference
		// at the far distance, literal, copy, end; then a match at stream start
		directed = '{8'hdc, 8'h00, 8'hff, 8'h00, 8'h0f, 8'h00, 8'h11, 8'hff, 8'hf1,
			8'h5a, 8'h00, 8'h21, 8'hff, 8'hf0,
			8'h03, 8'h00, 8'h01, 8'h00, 8'h00};
		foreach (directed[i])
			push_byte(directed[i]);
		n0 = compressed_q.size();
		while (compressed_q.size() - n0 < 250) begin
			if (!wrap_done && compressed_q.size() - n0 >= 120) begin
				// long stream of full copies: wraps the window and saturates the count
				s0        = compressed_q.size();
				send_calm = 1'b1;
				repeat (300) gen_token(5, 0, 1'b1);
				close_stream();
				drain_next = 1'b1;
				wrap_done  = 1'b1;
				n0 += compressed_q.size() - s0;
			end
			r         = $urandom_range(0, 99);
			send_calm = ($urandom_range(0, 3) == 0);
			if (r < 70) begin
				lp = $urandom_range(15, 85);
				repeat ($urandom_range(1, 20)) gen_token(lp, 8, 1'b0);
				close_stream();
			end else if (r < 85) begin
				repeat ($urandom_range(1, 6)) gen_token(50, 8, 1'b0);
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
				repeat ($urandom_range(0, 4)) gen_token(50, 8, 1'b0);
				close_stream();
			end else begin
				repeat ($urandom_range(1, 10)) push_byte(8'($urandom));
				close_stream();
			end
		end
	endtask

	task automatic check_result();
		result_t want;
		result_t got;
		got = result_t'{result_if.out_byte, result_if.status, result_if.last};
		if (decoded_q.size() == 0) begin
			if (errors < 10)
				$display("unexpected result %0d: byte %02h status %0d last %0b",
					results_seen, got.out_byte, got.status, got.last);
			errors++;
		end else begin
			want = decoded_q.pop_front();
			if (got.out_byte !== want.out_byte || got.status !== want.status
					|| got.last !== want.last) begin
				if (errors < 10)
					$display("mismatch at result %0d: expected %02h/%0d/%0b got %02h/%0d/%0b",
						results_seen, want.out_byte, want.status, want.last,
						got.out_byte, got.status, got.last);
				errors++;
			end
		end
		results_seen++;
	endtask

	// sender: one request per compressed byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_byte  <= 8'd0;
		end else begin
			if (src_valid && stream_if.ready)
				decode_byte(src_byte);
			if (!src_valid || stream_if.ready) begin
				if (send_idle > 0 && !long_hold) begin
					send_idle--;
					src_valid <= 1'b0;
				end else if (compressed_q.size() > 0
						&& (!compressed_q[0].drain_first || decoded_q.size() == 0)) begin
					next_item = compressed_q.pop_front();
					src_valid <= 1'b1;
					src_byte  <= next_item.data;
					send_idle = next_item.gap_after;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, calm stretches, and a long hold now and then
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			sink_ready <= 1'b0;
			long_hold  <= 1'b0;
		end else begin
			cycle_cnt <= cycle_cnt + 32'd1;
			if (result_if.valid && sink_ready)
				check_result();
			if (recv_idle > 0) begin
				recv_idle--;
				sink_ready <= 1'b0;
			end else if (results_seen >= next_hold) begin
				recv_idle = 400;
				next_hold += 2000;
				long_hold  <= 1'b1;
				sink_ready <= 1'b0;
			end else begin
				long_hold <= 1'b0;
				g = pick_gap();
				if (g == 0 || cycle_cnt[9:8] == 2'd0) begin
					sink_ready <= 1'b1;
				end else begin
					recv_idle = g - 1;
					sink_ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		dec_ctl = ctl_reset();
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (compressed_q.size() > 0 || src_valid || decoded_q.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
